// ----- hw/rtl/mhd_pkg.sv -----
// shared types and constants of the m-psk hard-decision demodulator
package mhd_pkg;

    // request kinds carried in the input tuser
    localparam logic REQ_DEMOD     = 1'b0;
    localparam logic REQ_MAP_WRITE = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_M   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_BITS = 1'b1;
    localparam int CFG_DATA_W = 9;

    // fixed field widths
    localparam int ORDER_W  = 9;
    localparam int QBITS_W  = 4;
    localparam int QBITS_MAX = 8;
    localparam int SYM_W    = 8;
    localparam int CONF_W   = 8;
    localparam int IDX_W    = 8;

    // cordic guard bits and angle accumulator width
    localparam int GUARD_BITS = 8;
    localparam int ANGLE_W    = 32;
    localparam int ATAN_ENTRIES = 24;

    // atan(2^-k) in units of 2^-32 turn
    localparam logic [ANGLE_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // control bits that travel beside each item
    typedef struct packed {
        logic valid;
        logic req;
        logic zero;
    } t_ctl;

endpackage

// ----- hw/rtl/mhd_cordic_cell.sv -----
// one vectoring cordic micro-rotation, registered, with its payload
module mhd_cordic_cell #(
    parameter int XW    = 27,
    parameter int SHIFT = 0,
    parameter logic [31:0] ANGLE = 32'd0,
    parameter int PAY_W = 80
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  mhd_pkg::t_ctl         i_ctl,
    input  logic signed [XW-1:0]  i_x,
    input  logic signed [XW-1:0]  i_y,
    input  logic [31:0]           i_z,
    input  logic [PAY_W-1:0]      i_pay,
    output mhd_pkg::t_ctl         o_ctl,
    output logic signed [XW-1:0]  o_x,
    output logic signed [XW-1:0]  o_y,
    output logic [31:0]           o_z,
    output logic [PAY_W-1:0]      o_pay
);

    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic [31:0]          n_z;

    assign w_dx = i_y >>> SHIFT;
    assign w_dy = i_x >>> SHIFT;

    // rotate toward the positive real axis, y sign picks the direction
    always_comb begin
        if (!i_y[XW-1]) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ANGLE;
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x   <= n_x;
            o_y   <= n_y;
            o_z   <= n_z;
            o_pay <= i_pay;
        end
    end

endmodule

// ----- hw/rtl/mhd_decide.sv -----
// sector decision, symbol map lookup and confidence scaling
module mhd_decide #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int PHASE_WIDTH  = 16,
    parameter int MAX_ORDER    = 256,
    parameter int PAY_W        = 80
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [mhd_pkg::ORDER_W-1:0]   i_order_m,
    input  logic [mhd_pkg::QBITS_W-1:0]   i_conf_bits,
    input  mhd_pkg::t_ctl                 i_ctl,
    input  logic [31:0]                   i_z,
    input  logic [PAY_W-1:0]              i_pay,
    output logic                          o_valid,
    output logic [mhd_pkg::SYM_W-1:0]     o_symbol,
    output logic [mhd_pkg::CONF_W-1:0]    o_conf
);

    localparam int SQ_W   = 2 * SAMPLE_WIDTH;
    localparam int MAG_W  = SQ_W + 1;
    localparam int PC_W   = MAG_W + mhd_pkg::CONF_W;
    localparam int PS_W   = PHASE_WIDTH + mhd_pkg::ORDER_W;
    localparam int AW     = $clog2(MAX_ORDER);
    localparam int FSH    = 2 * (SAMPLE_WIDTH - 2);

    // payload fields
    logic [mhd_pkg::IDX_W-1:0] w_idx;
    logic [mhd_pkg::SYM_W-1:0] w_sym;
    logic [SQ_W-1:0]           w_sqi;
    logic [SQ_W-1:0]           w_sqq;

    assign w_idx = i_pay[mhd_pkg::IDX_W-1:0];
    assign w_sym = i_pay[mhd_pkg::IDX_W +: mhd_pkg::SYM_W];
    assign w_sqi = i_pay[mhd_pkg::IDX_W + mhd_pkg::SYM_W +: SQ_W];
    assign w_sqq = i_pay[mhd_pkg::IDX_W + mhd_pkg::SYM_W + SQ_W +: SQ_W];

    // effective order and confidence maximum
    logic [mhd_pkg::ORDER_W-1:0] w_m;
    logic [mhd_pkg::QBITS_W-1:0] w_qb;
    logic [mhd_pkg::CONF_W-1:0]  w_qmax;

    always_comb begin
        if (i_order_m < mhd_pkg::ORDER_W'(2)) begin
            w_m = mhd_pkg::ORDER_W'(2);
        end else if (i_order_m > mhd_pkg::ORDER_W'(MAX_ORDER)) begin
            w_m = mhd_pkg::ORDER_W'(MAX_ORDER);
        end else begin
            w_m = i_order_m;
        end
        if (i_conf_bits > mhd_pkg::QBITS_W'(mhd_pkg::QBITS_MAX)) begin
            w_qb = mhd_pkg::QBITS_W'(mhd_pkg::QBITS_MAX);
        end else begin
            w_qb = i_conf_bits;
        end
        w_qmax = mhd_pkg::CONF_W'((9'd1 << w_qb) - 9'd1);
    end

    // stage 1: phase rounding and magnitude sum
    logic [31:0]              w_zr;
    logic [PHASE_WIDTH-1:0]   w_p;
    mhd_pkg::t_ctl            r_s1_ctl;
    logic [PHASE_WIDTH-1:0]   r_s1_p;
    logic [MAG_W-1:0]         r_s1_mag;
    logic [mhd_pkg::IDX_W-1:0] r_s1_idx;
    logic [mhd_pkg::SYM_W-1:0] r_s1_sym;

    assign w_zr = i_z + (32'd1 << (31 - PHASE_WIDTH));
    assign w_p  = i_ctl.zero ? '0 : w_zr[31 -: PHASE_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (i_en) begin
            r_s1_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_p   <= w_p;
            r_s1_mag <= MAG_W'(w_sqi) + MAG_W'(w_sqq);
            r_s1_idx <= w_idx;
            r_s1_sym <= w_sym;
        end
    end

    // stage 2: the two products
    mhd_pkg::t_ctl             r_s2_ctl;
    logic [PS_W-1:0]           r_s2_ps;
    logic [PC_W-1:0]           r_s2_pc;
    logic [mhd_pkg::IDX_W-1:0] r_s2_idx;
    logic [mhd_pkg::SYM_W-1:0] r_s2_sym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else if (i_en) begin
            r_s2_ctl <= r_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_ps  <= PS_W'(r_s1_p) * PS_W'(w_m);
            r_s2_pc  <= PC_W'(r_s1_mag) * PC_W'(w_qmax);
            r_s2_idx <= r_s1_idx;
            r_s2_sym <= r_s1_sym;
        end
    end

    // stage 3: sector wrap, confidence saturation, map access
    logic [PS_W-1:0]              w_sec_sum;
    logic [mhd_pkg::ORDER_W-1:0]  w_sec_full;
    logic [AW-1:0]                w_sector;
    logic [PC_W-1:0]              w_conf_sum;
    logic [PC_W-1:0]              w_conf_full;
    logic [mhd_pkg::CONF_W-1:0]   w_conf;
    logic                         w_map_we;

    assign w_sec_sum  = r_s2_ps + (PS_W'(1) << (PHASE_WIDTH - 1));
    assign w_sec_full = w_sec_sum[PS_W-1:PHASE_WIDTH];
    // rounding up to m lands back in sector zero
    assign w_sector   = (w_sec_full == w_m) ? '0 : w_sec_full[AW-1:0];

    assign w_conf_sum  = r_s2_pc + (PC_W'(1) << (FSH - 1));
    assign w_conf_full = w_conf_sum >> FSH;
    assign w_conf      = (w_conf_full > PC_W'(w_qmax)) ? w_qmax
                                                       : w_conf_full[mhd_pkg::CONF_W-1:0];

    // writes beyond the map depth are dropped
    assign w_map_we = i_en && r_s2_ctl.valid && (r_s2_ctl.req == mhd_pkg::REQ_MAP_WRITE)
                      && ({1'b0, r_s2_idx} < 9'(MAX_ORDER));

    logic [mhd_pkg::SYM_W-1:0] r_map [MAX_ORDER];

    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map[r_s2_idx[AW-1:0]] <= r_s2_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_symbol <= r_map[w_sector];
            o_conf   <= w_conf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_s2_ctl.valid && (r_s2_ctl.req == mhd_pkg::REQ_DEMOD);
        end
    end

endmodule

// ----- hw/rtl/mpsk_hard_demod_with_confidence_top.sv -----
// top level of the m-psk hard-decision demodulator with confidence output
//
// Each transfer on the input stream is either a complex sample to demodulate
// (tuser low) or a symbol map write (tuser high). A sample's phase comes from
// a vectoring cordic built as a row of PHASE_WIDTH registered cells, one
// micro-rotation per cell; the phase is split into order_m sectors (rounded
// to nearest) and the sector picks an entry of a loadable symbol map. The
// confidence is I^2+Q^2 scaled so that 1.0 maps to 2^conf_bits-1, rounded
// and saturated. Map writes travel down the same pipeline and reach the map
// in order, so a write only affects samples sent after it; map writes give
// no output transfer. Throughput is one item per clock while results are
// taken; a sample passes the input stage, PHASE_WIDTH cordic cells, phase
// rounding, sector and confidence multipliers and the map read. The whole
// pipeline moves together and stops only while the output register holds a
// result that is not taken. Map entries read before ever being written
// return arbitrary data. Configuration writes are taken at any time but
// must only be issued while the pipeline is empty.
module mpsk_hard_demod_with_confidence_top #(
    parameter int MAX_ORDER    = 256,
    parameter int SAMPLE_WIDTH = 16,
    parameter int PHASE_WIDTH  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // sample_i, sample_q, map_index, map_symbol, zero pad
    input  logic [((2*SAMPLE_WIDTH+16+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  logic                            s_axis_tuser,
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // symbol, confidence
    output logic [15:0]                     m_axis_tdata,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mhd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mhd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int S     = SAMPLE_WIDTH;
    localparam int G     = mhd_pkg::GUARD_BITS;
    localparam int XW    = S + G + 3;
    localparam int SQ_W  = 2 * S;
    localparam int PAY_W = mhd_pkg::IDX_W + mhd_pkg::SYM_W + 2 * SQ_W;

    // configuration registers, always ready
    logic [mhd_pkg::ORDER_W-1:0] r_order_m;
    logic [mhd_pkg::QBITS_W-1:0] r_conf_bits;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_m   <= mhd_pkg::ORDER_W'(4);
            r_conf_bits <= mhd_pkg::QBITS_W'(8);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mhd_pkg::CFG_ORDER_M: begin
                    r_order_m <= i_cfg_data[mhd_pkg::ORDER_W-1:0];
                end
                mhd_pkg::CFG_CONF_BITS: begin
                    r_conf_bits <= i_cfg_data[mhd_pkg::QBITS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // the pipeline advances unless a finished result waits at the output
    logic w_en;
    logic w_out_valid;

    assign w_en          = !w_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    // unpack the input transfer
    logic signed [S-1:0]       w_si;
    logic signed [S-1:0]       w_sq;
    logic [mhd_pkg::IDX_W-1:0] w_idx;
    logic [mhd_pkg::SYM_W-1:0] w_sym;

    assign w_si  = s_axis_tdata[S-1:0];
    assign w_sq  = s_axis_tdata[2*S-1:S];
    assign w_idx = s_axis_tdata[2*S +: mhd_pkg::IDX_W];
    assign w_sym = s_axis_tdata[2*S + mhd_pkg::IDX_W +: mhd_pkg::SYM_W];

    // guard-scaled vector and squares
    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;
    logic signed [SQ_W-1:0] w_sqi;
    logic signed [SQ_W-1:0] w_sqq;

    assign w_xs  = {{(XW-S-G){w_si[S-1]}}, w_si, {G{1'b0}}};
    assign w_ys  = {{(XW-S-G){w_sq[S-1]}}, w_sq, {G{1'b0}}};
    assign w_sqi = w_si * w_si;
    assign w_sqq = w_sq * w_sq;

    // input stage: fold the left half plane over by a half turn
    mhd_pkg::t_ctl        r_pre_ctl;
    logic signed [XW-1:0] r_pre_x;
    logic signed [XW-1:0] r_pre_y;
    logic [31:0]          r_pre_z;
    logic [PAY_W-1:0]     r_pre_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_ctl <= '0;
        end else if (w_en) begin
            r_pre_ctl.valid <= s_axis_tvalid;
            r_pre_ctl.req   <= s_axis_tuser;
            // zero sample has phase zero by definition
            r_pre_ctl.zero  <= (w_si == '0) && (w_sq == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_si[S-1]) begin
                r_pre_x <= -w_xs;
                r_pre_y <= -w_ys;
                r_pre_z <= 32'h8000_0000;
            end else begin
                r_pre_x <= w_xs;
                r_pre_y <= w_ys;
                r_pre_z <= '0;
            end
            r_pre_pay <= {$unsigned(w_sqq), $unsigned(w_sqi), w_sym, w_idx};
        end
    end

    // cordic chain
    mhd_pkg::t_ctl        w_ctl [PHASE_WIDTH+1];
    logic signed [XW-1:0] w_x   [PHASE_WIDTH+1];
    logic signed [XW-1:0] w_y   [PHASE_WIDTH+1];
    logic [31:0]          w_z   [PHASE_WIDTH+1];
    logic [PAY_W-1:0]     w_pay [PHASE_WIDTH+1];

    assign w_ctl[0] = r_pre_ctl;
    assign w_x[0]   = r_pre_x;
    assign w_y[0]   = r_pre_y;
    assign w_z[0]   = r_pre_z;
    assign w_pay[0] = r_pre_pay;

    for (genvar k = 0; k < PHASE_WIDTH; k++) begin : g_cell
        mhd_cordic_cell #(
            .XW    (XW),
            .SHIFT (k),
            .ANGLE (mhd_pkg::ATAN_TAB[k]),
            .PAY_W (PAY_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[k]),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_z     (w_z[k]),
            .i_pay   (w_pay[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_z     (w_z[k+1]),
            .o_pay   (w_pay[k+1])
        );
    end

    // sector decision, map and confidence; holds the output register
    logic [mhd_pkg::SYM_W-1:0]  w_symbol;
    logic [mhd_pkg::CONF_W-1:0] w_conf;

    mhd_decide #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PHASE_WIDTH  (PHASE_WIDTH),
        .MAX_ORDER    (MAX_ORDER),
        .PAY_W        (PAY_W)
    ) u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_order_m    (r_order_m),
        .i_conf_bits  (r_conf_bits),
        .i_ctl        (w_ctl[PHASE_WIDTH]),
        .i_z          (w_z[PHASE_WIDTH]),
        .i_pay        (w_pay[PHASE_WIDTH]),
        .o_valid      (w_out_valid),
        .o_symbol     (w_symbol),
        .o_conf       (w_conf)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {w_conf, w_symbol};

endmodule

// ----- dv/mpsk_hard_demod_with_confidence_top_tb.sv -----
// self-checking testbench of the m-psk hard-decision demodulator with confidence output
module mpsk_hard_demod_with_confidence_top_tb;

    localparam int  SAMPLE_W     = 16;
    localparam int  PHASE_W      = 16;
    localparam int  MAP_DEPTH    = 256;
    localparam int  TDATA_W      = ((2*SAMPLE_W+16+7)/8)*8;
    // input stage, cordic cells, rounding, multipliers, map read
    localparam int  PIPE_LATENCY = PHASE_W + 4;
    localparam real TWO_PI       = 6.283185307179586;

    // one expected output transfer, with the sample kept for reporting
    typedef struct {
        logic [7:0] symbol;
        logic [7:0] confidence;
        int         si;
        int         sq;
    } t_decision;

    // own model of the demodulator: config, symbol map and pending decisions
    class hard_decision_checker;
        int unsigned order_m;
        int unsigned conf_bits;
        logic [7:0]  symbol_map [MAP_DEPTH];
        bit          map_written [MAP_DEPTH];
        t_decision   pending_decisions [$];
        int unsigned mismatches;

        function new();
            order_m    = 4;
            conf_bits  = 8;
            mismatches = 0;
            foreach (symbol_map[n]) begin
                symbol_map[n]  = 8'h00;
                map_written[n] = 1'b0;
            end
        endfunction

        function void write_register(logic [mhd_pkg::CFG_IDX_W-1:0] idx,
                                     logic [mhd_pkg::CFG_DATA_W-1:0] value);
            if (idx == mhd_pkg::CFG_ORDER_M) begin
                order_m = 32'(value);
            end else begin
                conf_bits = 32'(value[3:0]);
            end
        endfunction

        function int unsigned eff_order();
            int unsigned m;
            m = order_m;
            if (m < 2) m = 2;
            if (m > MAP_DEPTH) m = MAP_DEPTH;
            return m;
        endfunction

        // atan(2^-k) in 2^-32 turn
        function longint arctan_step(int k);
            case (k)
                0:  return 536870912;
                1:  return 316933406;
                2:  return 167458907;
                3:  return 85004756;
                4:  return 42667331;
                5:  return 21354465;
                6:  return 10679838;
                7:  return 5340245;
                8:  return 2670163;
                9:  return 1335087;
                10: return 667544;
                11: return 333772;
                12: return 166886;
                13: return 83443;
                14: return 41722;
                15: return 20861;
                16: return 10430;
                17: return 5215;
                18: return 2608;
                19: return 1304;
                20: return 652;
                21: return 326;
                22: return 163;
                23: return 81;
                default: return 0;
            endcase
        endfunction

        // vectoring cordic, angle accumulated on 32 bits of a turn
        function int unsigned phase_word(longint x, longint y);
            longint            z;
            longint            dx;
            longint            dy;
            longint unsigned   p;
            int                k;
            if (x == 0 && y == 0) return 0;
            x = x * 256;
            y = y * 256;
            z = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = longint'(1) << 31;
            end
            for (k = 0; k < PHASE_W; k++) begin
                dx = y >>> k;
                dy = x >>> k;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + arctan_step(k);
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - arctan_step(k);
                end
            end
            p = z & 64'hFFFF_FFFF;
            p = (p + (64'd1 << (31 - PHASE_W))) >> (32 - PHASE_W);
            return 32'(p & ((64'd1 << PHASE_W) - 1));
        endfunction

        function int unsigned sector_of(int si, int sq);
            longint unsigned p;
            longint unsigned m;
            p = phase_word(si, sq);
            m = eff_order();
            return 32'(((p * m + (64'd1 << (PHASE_W - 1))) >> PHASE_W) % m);
        endfunction

        function logic [7:0] confidence_of(int si, int sq);
            longint unsigned a;
            longint unsigned b;
            longint unsigned qmax;
            longint unsigned conf;
            int unsigned     qb;
            a    = longint'(si) * longint'(si);
            b    = longint'(sq) * longint'(sq);
            qb   = (conf_bits > 8) ? 8 : conf_bits;
            qmax = (64'd1 << qb) - 1;
            conf = ((a + b) * qmax + (64'd1 << (2*(SAMPLE_W-2) - 1))) >> (2*(SAMPLE_W-2));
            if (conf > qmax) conf = qmax;
            return conf[7:0];
        endfunction

        // called on each accepted input transfer
        function void note_item(logic req, logic signed [15:0] si, logic signed [15:0] sq,
                                logic [7:0] idx, logic [7:0] sym);
            t_decision d;
            if (req == mhd_pkg::REQ_MAP_WRITE) begin
                symbol_map[idx]  = sym;
                map_written[idx] = 1'b1;
            end else begin
                d.si         = si;
                d.sq         = sq;
                d.symbol     = symbol_map[sector_of(si, sq)];
                d.confidence = confidence_of(si, sq);
                pending_decisions.push_back(d);
            end
        endfunction

        // called on each accepted output transfer
        function void check_decision(logic [15:0] data);
            t_decision d;
            if (pending_decisions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output transfer: symbol %0d conf %0d",
                             data[7:0], data[15:8]);
                return;
            end
            d = pending_decisions.pop_front();
            if (data[7:0] !== d.symbol || data[15:8] !== d.confidence) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: sample (%0d,%0d) expected symbol %0d conf %0d,",
                              " got symbol %0d conf %0d"},
                             d.si, d.sq, d.symbol, d.confidence, data[7:0], data[15:8]);
            end
        endfunction

        function int unsigned close_out();
            mismatches += pending_decisions.size();
            return mismatches;
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // sample_i, sample_q, map_index, map_symbol
    logic [TDATA_W-1:0]              s_axis_tdata;
    // req_type
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // symbol, confidence
    logic [15:0]                     m_axis_tdata;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [mhd_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [mhd_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    hard_decision_checker decisions;

    // idling controls shared by the stimulus and the result sink
    bit sender_gaps;
    bit receiver_gaps;
    bit hold_off_request;

    mpsk_hard_demod_with_confidence_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard limit on the run, far beyond the slowest correct run
    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // one input transfer, driven at the falling edge and taken at the rising edge
    task automatic send_item(input logic req, input logic signed [15:0] si,
                             input logic signed [15:0] sq, input logic [7:0] idx,
                             input logic [7:0] sym);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {sym, idx, sq, si};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        decisions.note_item(req, si, sq, idx, sym);
        @(negedge i_clk);
    endtask

    // a sample whose sector was never loaded gets a map write first,
    // so no unwritten entry is ever read
    task automatic send_sample(input logic signed [15:0] si, input logic signed [15:0] sq);
        int unsigned s;
        s = decisions.sector_of(si, sq);
        if (!decisions.map_written[s])
            send_item(mhd_pkg::REQ_MAP_WRITE, 16'($urandom), 16'($urandom), s[7:0],
                      8'($urandom));
        send_item(mhd_pkg::REQ_DEMOD, si, sq, 8'($urandom), 8'($urandom));
    endtask

    // random sample: mostly near constellation points, some on sector
    // boundaries, some anywhere in the full range, some close to zero
    task automatic draw_sample(output logic signed [15:0] si, output logic signed [15:0] sq);
        int  kind;
        int  m;
        int  s;
        int  off;
        real amp;
        real ang;
        kind = $urandom_range(0, 99);
        m    = decisions.eff_order();
        s    = $urandom_range(0, m - 1);
        if (kind < 70) begin
            off = $urandom_range(0, 200);
            off = off - 100;
            amp = $urandom_range(0, 32767);
            // exact midpoint between two sectors for about a third of them
            if (kind < 25)
                ang = TWO_PI * (s + 0.5) / m;
            else
                ang = TWO_PI * (s + off / 400.0) / m;
            si = 16'($rtoi(amp * $cos(ang)));
            sq = 16'($rtoi(amp * $sin(ang)));
        end else if (kind < 90) begin
            si = 16'($urandom);
            sq = 16'($urandom);
        end else begin
            off = $urandom_range(0, 8);
            si  = 16'(off - 4);
            off = $urandom_range(0, 8);
            sq  = 16'(off - 4);
        end
    endtask

    // config transfer; valid is lowered by the caller once all writes are done
    task automatic cfg_write(input logic [mhd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mhd_pkg::CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        decisions.write_register(idx, value);
        @(negedge i_clk);
    endtask

    task automatic set_config(input int unsigned order, input int unsigned qbits);
        cfg_write(mhd_pkg::CFG_ORDER_M, order[mhd_pkg::CFG_DATA_W-1:0]);
        cfg_write(mhd_pkg::CFG_CONF_BITS, qbits[mhd_pkg::CFG_DATA_W-1:0]);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every expected result, then let trailing map writes clear
    task automatic drain_pipeline();
        int n;
        s_axis_tvalid <= 1'b0;
        for (n = 0; n < 20000 && decisions.pending_decisions.size() != 0; n++)
            @(negedge i_clk);
        repeat (PIPE_LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic run_phase(input int unsigned order, input int unsigned qbits,
                             input bit sgaps, input bit rgaps, input int n_items,
                             input bit hold);
        logic signed [15:0] si;
        logic signed [15:0] sq;
        int                 i;
        sender_gaps   = sgaps;
        receiver_gaps = rgaps;
        set_config(order, qbits);
        if (hold) hold_off_request = 1'b1;
        for (i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                send_item(mhd_pkg::REQ_MAP_WRITE, 16'($urandom), 16'($urandom),
                          8'($urandom), 8'($urandom));
            end else begin
                draw_sample(si, sq);
                send_sample(si, sq);
            end
        end
        drain_pipeline();
    endtask

    // result sink: random stalls, and one long hold-off on request that
    // backs the pipeline up into the input
    initial begin : result_sink
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = receiver_gaps ? $urandom_range(0, 3) : 0;
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                gap = 6 * PIPE_LATENCY;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            decisions.check_decision(m_axis_tdata);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int unsigned fails;
        i_rst_n          = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = mhd_pkg::REQ_DEMOD;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = mhd_pkg::CFG_ORDER_M;
        i_cfg_data       = '0;
        sender_gaps      = 1'b0;
        receiver_gaps    = 1'b0;
        hold_off_request = 1'b0;
        decisions        = new();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed part at the reset config (order 4, 8 confidence bits)
        send_item(mhd_pkg::REQ_MAP_WRITE, 16'sh8000, 16'sh7fff, 8'd0, 8'hA5);
        send_item(mhd_pkg::REQ_MAP_WRITE, 16'sh7fff, 16'sh8000, 8'd1, 8'h00);
        send_item(mhd_pkg::REQ_MAP_WRITE, 16'sh0000, 16'shffff, 8'd2, 8'h5A);
        send_item(mhd_pkg::REQ_MAP_WRITE, 16'shffff, 16'sh0000, 8'd3, 8'hFF);
        send_item(mhd_pkg::REQ_MAP_WRITE, 16'sh1234, 16'sh4321, 8'd255, 8'hFF);
        // zero sample: phase 0, confidence 0
        send_sample(16'sd0, 16'sd0);
        // axis extremes, the negative real one through the half-turn pre-rotation
        send_sample(16'sd32767, 16'sd0);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(16'sd0, 16'sd32767);
        send_sample(16'sd0, -16'sd32768);
        // corners, confidence saturates
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768);
        // unit magnitude gives exactly the maximum
        send_sample(16'sd16384, 16'sd0);
        send_sample(16'sd11585, 16'sd11585);
        // smallest nonzero vectors
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd0, -16'sd1);
        send_sample(16'sd1, 16'sd1);
        send_sample(-16'sd1, -16'sd1);
        drain_pipeline();

        // random part over several settings, out-of-range values included
        run_phase(2,   1,  1'b1, 1'b1, 48, 1'b0);
        run_phase(256, 8,  1'b1, 1'b1, 48, 1'b0);
        run_phase(0,   0,  1'b0, 1'b0, 48, 1'b0);
        run_phase(1,   15, 1'b1, 1'b0, 48, 1'b0);
        run_phase(511, 9,  1'b0, 1'b1, 48, 1'b0);
        run_phase(8,   3,  1'b1, 1'b1, 48, 1'b0);
        run_phase(16,  4,  1'b0, 1'b0, 48, 1'b0);
        run_phase(257, 8,  1'b1, 1'b1, 48, 1'b0);
        run_phase(3,   5,  1'b1, 1'b1, 48, 1'b0);
        run_phase(64,  7,  1'b1, 1'b1, 48, 1'b0);
        run_phase(5,   2,  1'b1, 1'b1, 48, 1'b0);
        run_phase(128, 6,  1'b1, 1'b1, 48, 1'b0);
        // full-rate sender against a long receiver hold-off
        run_phase(32,  8,  1'b0, 1'b1, 48, 1'b1);
        run_phase($urandom_range(2, 256), $urandom_range(0, 15), 1'b1, 1'b1, 32, 1'b0);

        fails = decisions.close_out();
        if (fails == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/mhd_pkg.sv
hw/rtl/mhd_cordic_cell.sv
hw/rtl/mhd_decide.sv
hw/rtl/mpsk_hard_demod_with_confidence_top.sv
dv/mpsk_hard_demod_with_confidence_top_tb.sv
